// ===== sv/word_length_statistics_core_defines.svh =====
// Assertion macros used by the checker of the word length statistics core.
`ifndef WORD_LENGTH_STATISTICS_CORE_DEFINES_SVH
`define WORD_LENGTH_STATISTICS_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define WLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define WLS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== sv/wls_pkg.sv =====
`default_nettype none

package wls_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int SQ_W = 24;
    localparam logic [SQ_W-1:0] SQ_SUM_MAX = '1;

    localparam int MEAN_W         = 24;
    localparam int DEV_W          = 16;
    localparam int MEAN_FRAC      = 8;
    localparam int DEV_SCALE      = 16;
    localparam int DIV_STEPS      = 32;
    localparam int SQRT_STEPS     = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_MEAN,
        ST_MUL_CC,
        ST_MUL_SS,
        ST_MUL_CCC,
        ST_MUL_QCC,
        ST_MUL_NSS,
        ST_MUL_NEG,
        ST_CHK_OVF,
        ST_DIV_DEV,
        ST_SQRT,
        ST_DONE
    } eng_state_t;

    typedef struct packed {
        logic start;
        logic ack;
    } eng_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } eng_sts_t;

endpackage

`default_nettype wire

// ===== sv/wls_stats_unit.sv =====
`default_nettype none

module wls_stats_unit #(
    parameter int CW = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wls_pkg::eng_ctl_t            ctl_i,
    output wls_pkg::eng_sts_t            sts_o,
    input  wire [CW-1:0]                 sum_i,
    input  wire [CW-1:0]                 cnt_i,
    input  wire [CW-1:0]                 words_i,
    input  wire [wls_pkg::SQ_W-1:0]      sq_i,
    output logic [wls_pkg::MEAN_W-1:0]   mean_o,
    output logic [wls_pkg::DEV_W-1:0]    dev_o
);

    localparam int PW_A = wls_pkg::SQ_W + 2 * CW;
    localparam int PW_B = 3 * CW + wls_pkg::DEV_SCALE;
    localparam int AW   = ((PW_A > PW_B) ? PW_A : PW_B) + 2;
    localparam int SW   = wls_pkg::DIV_STEPS;
    localparam int CNTW = $clog2(wls_pkg::DIV_STEPS + 1);

    wls_pkg::eng_state_t state_reg, state_next;

    logic [CNTW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]            acc_reg, acc_next;
    logic [AW-1:0]            mcand_reg, mcand_next;
    logic [SW-1:0]            shf_reg, shf_next;
    logic [CW-1:0]            s_reg, s_next;
    logic [CW-1:0]            c_reg, c_next;
    logic [CW-1:0]            n_reg, n_next;
    logic [wls_pkg::SQ_W-1:0] q_reg, q_next;
    logic [2*CW-1:0]          cc_reg, cc_next;
    logic [2*CW-1:0]          ss_reg, ss_next;
    logic [3*CW-1:0]          ccc_reg, ccc_next;
    logic [wls_pkg::MEAN_W-1:0] mean_reg, mean_next;
    logic [wls_pkg::DEV_W-1:0]  dev_reg, dev_next;

    logic [AW-1:0] opa;
    logic [AW-1:0] opb;
    logic          sub;
    logic [AW-1:0] sum;
    logic          nonneg;
    logic [AW-1:0] prod;
    logic [AW-1:0] rem_next;
    logic [SW-1:0] shf_div;
    logic [AW-1:0] root_next;
    logic          last;

    // Shared add/subtract unit.
    always_comb begin
        opa = acc_reg;
        opb = mcand_reg;
        sub = 1'b0;
        case (state_reg)
            wls_pkg::ST_MUL_CC, wls_pkg::ST_MUL_SS, wls_pkg::ST_MUL_CCC,
            wls_pkg::ST_MUL_QCC, wls_pkg::ST_MUL_NSS: begin
                sub = 1'b0;
            end
            wls_pkg::ST_MUL_NEG, wls_pkg::ST_CHK_OVF: begin
                sub = 1'b1;
            end
            wls_pkg::ST_DIV_MEAN, wls_pkg::ST_DIV_DEV: begin
                opa = {acc_reg[AW-2:0], shf_reg[SW-1]};
                sub = 1'b1;
            end
            wls_pkg::ST_SQRT: begin
                opb = mcand_reg | AW'(shf_reg);
                sub = 1'b1;
            end
            default: begin
                sub = 1'b0;
            end
        endcase
    end

    assign sum       = opa + (sub ? ~opb : opb) + AW'(sub);
    assign nonneg    = ~sum[AW-1];
    assign prod      = shf_reg[0] ? sum : acc_reg;
    assign rem_next  = nonneg ? sum : opa;
    assign shf_div   = {shf_reg[SW-2:0], nonneg};
    assign root_next = nonneg ? ((mcand_reg >> 1) | AW'(shf_reg)) : (mcand_reg >> 1);
    assign last      = (cnt_reg == CNTW'(1));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wls_pkg::ST_IDLE: begin
                if (ctl_i.start) begin
                    state_next = wls_pkg::ST_DIV_MEAN;
                end
            end
            wls_pkg::ST_DIV_MEAN: begin
                if (last) begin
                    state_next = wls_pkg::ST_MUL_CC;
                end
            end
            wls_pkg::ST_MUL_CC: begin
                if (last) begin
                    state_next = wls_pkg::ST_MUL_SS;
                end
            end
            wls_pkg::ST_MUL_SS: begin
                if (last) begin
                    state_next = wls_pkg::ST_MUL_CCC;
                end
            end
            wls_pkg::ST_MUL_CCC: begin
                if (last) begin
                    state_next = wls_pkg::ST_MUL_QCC;
                end
            end
            wls_pkg::ST_MUL_QCC: begin
                if (last) begin
                    state_next = wls_pkg::ST_MUL_NSS;
                end
            end
            wls_pkg::ST_MUL_NSS: begin
                if (last) begin
                    state_next = wls_pkg::ST_MUL_NEG;
                end
            end
            wls_pkg::ST_MUL_NEG: begin
                if (last) begin
                    state_next = wls_pkg::ST_CHK_OVF;
                end
            end
            wls_pkg::ST_CHK_OVF: begin
                if (acc_reg[AW-1] || (acc_reg == '0) || nonneg) begin
                    state_next = wls_pkg::ST_DONE;
                end else begin
                    state_next = wls_pkg::ST_DIV_DEV;
                end
            end
            wls_pkg::ST_DIV_DEV: begin
                if (last) begin
                    state_next = wls_pkg::ST_SQRT;
                end
            end
            wls_pkg::ST_SQRT: begin
                if (last) begin
                    state_next = wls_pkg::ST_DONE;
                end
            end
            wls_pkg::ST_DONE: begin
                if (ctl_i.ack) begin
                    state_next = wls_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = wls_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        shf_next   = shf_reg;
        s_next     = s_reg;
        c_next     = c_reg;
        n_next     = n_reg;
        q_next     = q_reg;
        cc_next    = cc_reg;
        ss_next    = ss_reg;
        ccc_next   = ccc_reg;
        mean_next  = mean_reg;
        dev_next   = dev_reg;
        case (state_reg)
            wls_pkg::ST_IDLE: begin
                if (ctl_i.start) begin
                    s_next     = sum_i;
                    c_next     = cnt_i;
                    n_next     = words_i;
                    q_next     = sq_i;
                    acc_next   = '0;
                    mcand_next = AW'(cnt_i);
                    shf_next   = SW'({sum_i, {wls_pkg::MEAN_FRAC{1'b0}}});
                    cnt_next   = CNTW'(wls_pkg::DIV_STEPS);
                end
            end
            wls_pkg::ST_DIV_MEAN: begin
                acc_next = rem_next;
                shf_next = shf_div;
                cnt_next = cnt_reg - CNTW'(1);
                if (last) begin
                    mean_next  = ((shf_div >> wls_pkg::MEAN_W) != '0) ? '1
                                                                      : wls_pkg::MEAN_W'(shf_div);
                    acc_next   = '0;
                    mcand_next = AW'(c_reg);
                    shf_next   = SW'(c_reg);
                    cnt_next   = CNTW'(CW);
                end
            end
            wls_pkg::ST_MUL_CC, wls_pkg::ST_MUL_SS, wls_pkg::ST_MUL_CCC,
            wls_pkg::ST_MUL_QCC, wls_pkg::ST_MUL_NSS, wls_pkg::ST_MUL_NEG: begin
                acc_next   = prod;
                mcand_next = mcand_reg << 1;
                shf_next   = shf_reg >> 1;
                cnt_next   = cnt_reg - CNTW'(1);
                if (last) begin
                    case (state_reg)
                        wls_pkg::ST_MUL_CC: begin
                            cc_next    = (2*CW)'(prod);
                            acc_next   = '0;
                            mcand_next = AW'(s_reg);
                            shf_next   = SW'(s_reg);
                            cnt_next   = CNTW'(CW);
                        end
                        wls_pkg::ST_MUL_SS: begin
                            ss_next    = (2*CW)'(prod);
                            acc_next   = '0;
                            mcand_next = AW'(cc_reg);
                            shf_next   = SW'(c_reg);
                            cnt_next   = CNTW'(CW);
                        end
                        wls_pkg::ST_MUL_CCC: begin
                            ccc_next   = (3*CW)'(prod);
                            acc_next   = '0;
                            mcand_next = AW'(cc_reg);
                            shf_next   = SW'(q_reg);
                            cnt_next   = CNTW'(wls_pkg::SQ_W);
                        end
                        wls_pkg::ST_MUL_QCC: begin
                            mcand_next = AW'(ss_reg);
                            shf_next   = SW'(n_reg);
                            cnt_next   = CNTW'(CW);
                        end
                        wls_pkg::ST_MUL_NSS: begin
                            mcand_next = AW'({ss_reg, 1'b0});
                            shf_next   = SW'(c_reg);
                            cnt_next   = CNTW'(CW);
                        end
                        default: begin
                            mcand_next = AW'({ccc_reg, {wls_pkg::DEV_SCALE{1'b0}}});
                        end
                    endcase
                end
            end
            wls_pkg::ST_CHK_OVF: begin
                if (acc_reg[AW-1] || (acc_reg == '0)) begin
                    dev_next = '0;
                end else if (nonneg) begin
                    dev_next = '1;
                end else begin
                    acc_next   = acc_reg >> wls_pkg::DEV_SCALE;
                    shf_next   = SW'({acc_reg[wls_pkg::DEV_SCALE-1:0],
                                      {wls_pkg::DEV_SCALE{1'b0}}});
                    mcand_next = AW'(ccc_reg);
                    cnt_next   = CNTW'(wls_pkg::DIV_STEPS);
                end
            end
            wls_pkg::ST_DIV_DEV: begin
                acc_next = rem_next;
                shf_next = shf_div;
                cnt_next = cnt_reg - CNTW'(1);
                if (last) begin
                    acc_next   = AW'(shf_div);
                    mcand_next = '0;
                    shf_next   = SW'(1) << (SW - 2);
                    cnt_next   = CNTW'(wls_pkg::SQRT_STEPS);
                end
            end
            wls_pkg::ST_SQRT: begin
                if (nonneg) begin
                    acc_next = sum;
                end
                mcand_next = root_next;
                shf_next   = shf_reg >> 2;
                cnt_next   = cnt_reg - CNTW'(1);
                if (last) begin
                    dev_next = wls_pkg::DEV_W'(root_next);
                end
            end
            default: begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wls_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        shf_reg   <= shf_next;
        s_reg     <= s_next;
        c_reg     <= c_next;
        n_reg     <= n_next;
        q_reg     <= q_next;
        cc_reg    <= cc_next;
        ss_reg    <= ss_next;
        ccc_reg   <= ccc_next;
        mean_reg  <= mean_next;
        dev_reg   <= dev_next;
    end

    assign sts_o.busy = (state_reg != wls_pkg::ST_IDLE);
    assign sts_o.done = (state_reg == wls_pkg::ST_DONE);
    assign mean_o     = mean_reg;
    assign dev_o      = dev_reg;

endmodule

`default_nettype wire

// ===== sv/word_length_statistics_core.sv =====
// Word length statistics over a byte stream. Letters, spaces and skipped punctuation are
// taken at one byte per cycle while the statistics unit is idle. A zero byte ends the
// sentence: the block then runs a sequenced add/subtract unit that forms the mean by
// restoring division, the squared deviation sum by shift-and-add products, a second
// restoring division and a bit-pair square root; when the deviation is zero or
// saturates, the second division and the root are skipped. s_ready is low while the
// unit computes and for as long as a finished result waits for the output register.
// The result item sits in an output register, so bytes of the next sentence are taken
// while it waits.
`default_nettype none

module word_length_statistics_core #(
    parameter int WORD_LEN_MAX = 255,
    parameter int COUNT_MAX    = 65535
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire [7:0]   s_ch,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_min_len,
    output logic [7:0]  m_max_len,
    output logic [15:0] m_letter_total,
    output logic [15:0] m_word_count,
    output logic [23:0] m_mean_q8,
    output logic [15:0] m_stddev_q8
);

    localparam int LW = $clog2(WORD_LEN_MAX + 1);
    localparam int CW = $clog2(COUNT_MAX + 1);
    localparam int XW = ((CW > LW) ? CW : LW) + 1;
    localparam int QW = (((2 * LW) > wls_pkg::SQ_W) ? (2 * LW) : wls_pkg::SQ_W) + 1;
    localparam logic [LW-1:0] LEN_MAX = LW'(WORD_LEN_MAX);
    localparam logic [CW-1:0] CNT_MAX = CW'(COUNT_MAX);

    logic [LW-1:0]            cur_len_reg, cur_len_next;
    logic [LW-1:0]            min_reg, min_next;
    logic [LW-1:0]            max_reg, max_next;
    logic [CW-1:0]            sum_reg, sum_next;
    logic [wls_pkg::SQ_W-1:0] sq_reg, sq_next;
    logic [CW-1:0]            words_reg, words_next;
    logic [CW-1:0]            spaces_reg, spaces_next;
    logic                     m_valid_reg, m_valid_next;

    logic [7:0]  min_hold_reg;
    logic [7:0]  max_hold_reg;
    logic [15:0] sum_hold_reg;
    logic [15:0] cnt_hold_reg;

    logic [7:0]  m_min_reg;
    logic [7:0]  m_max_reg;
    logic [15:0] m_sum_reg;
    logic [15:0] m_cnt_reg;
    logic [23:0] m_mean_reg;
    logic [15:0] m_dev_reg;

    logic                     s_accept;
    logic                     is_skip;
    logic                     term_accept;
    logic                     has_word;
    logic [2*LW-1:0]          len_sq;
    logic [XW-1:0]            sum_wide;
    logic [QW-1:0]            sq_wide;
    logic [LW-1:0]            min_f;
    logic [LW-1:0]            max_f;
    logic [CW-1:0]            sum_f;
    logic [wls_pkg::SQ_W-1:0] sq_f;
    logic [CW-1:0]            words_f;
    logic [CW-1:0]            spaces_inc;
    logic [LW-1:0]            cur_inc;
    logic                     load;

    wls_pkg::eng_ctl_t          eng_ctl;
    wls_pkg::eng_sts_t          eng_sts;
    logic [wls_pkg::MEAN_W-1:0] eng_mean;
    logic [wls_pkg::DEV_W-1:0]  eng_dev;

    assign s_ready     = ~eng_sts.busy;
    assign s_accept    = s_valid & s_ready;
    assign is_skip     = s_ch inside {wls_pkg::CH_DOT, wls_pkg::CH_COMMA, wls_pkg::CH_COLON,
                                      wls_pkg::CH_SEMI, wls_pkg::CH_BANG, wls_pkg::CH_QUEST,
                                      wls_pkg::CH_NL};
    assign term_accept = s_accept && (s_ch == wls_pkg::CH_NUL);

    // Statistics with the current word closed, used by a space and by the terminator.
    assign has_word = (cur_len_reg != '0);
    assign len_sq   = (2*LW)'(cur_len_reg) * (2*LW)'(cur_len_reg);
    assign sum_wide = XW'(sum_reg) + XW'(cur_len_reg);
    assign sq_wide  = QW'(sq_reg) + QW'(len_sq);

    always_comb begin
        min_f   = min_reg;
        max_f   = max_reg;
        sum_f   = sum_reg;
        sq_f    = sq_reg;
        words_f = words_reg;
        if (has_word) begin
            min_f   = (cur_len_reg < min_reg) ? cur_len_reg : min_reg;
            max_f   = (cur_len_reg > max_reg) ? cur_len_reg : max_reg;
            sum_f   = (sum_wide > XW'(COUNT_MAX)) ? CNT_MAX : CW'(sum_wide);
            sq_f    = (sq_wide > QW'(wls_pkg::SQ_SUM_MAX)) ? wls_pkg::SQ_SUM_MAX
                                                          : wls_pkg::SQ_W'(sq_wide);
            words_f = (words_reg < CNT_MAX) ? words_reg + CW'(1) : words_reg;
        end
    end

    assign spaces_inc = (spaces_reg < CNT_MAX) ? spaces_reg + CW'(1) : spaces_reg;
    assign cur_inc    = (cur_len_reg < LEN_MAX) ? cur_len_reg + LW'(1) : cur_len_reg;

    always_comb begin
        cur_len_next = cur_len_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        sum_next     = sum_reg;
        sq_next      = sq_reg;
        words_next   = words_reg;
        spaces_next  = spaces_reg;
        if (s_accept) begin
            if (s_ch == wls_pkg::CH_SPACE) begin
                spaces_next  = spaces_inc;
                min_next     = min_f;
                max_next     = max_f;
                sum_next     = sum_f;
                sq_next      = sq_f;
                words_next   = words_f;
                cur_len_next = '0;
            end else if (is_skip) begin
                cur_len_next = cur_len_reg;
            end else if (s_ch != wls_pkg::CH_NUL) begin
                cur_len_next = cur_inc;
            end else begin
                cur_len_next = '0;
                min_next     = LEN_MAX;
                max_next     = '0;
                sum_next     = '0;
                sq_next      = '0;
                words_next   = '0;
                spaces_next  = '0;
            end
        end
    end

    assign eng_ctl.start = term_accept;
    assign eng_ctl.ack   = load;
    assign load          = eng_sts.done && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    wls_stats_unit #(
        .CW(CW)
    ) u_stats (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_i   (eng_ctl),
        .sts_o   (eng_sts),
        .sum_i   (sum_f),
        .cnt_i   (spaces_inc),
        .words_i (words_f),
        .sq_i    (sq_f),
        .mean_o  (eng_mean),
        .dev_o   (eng_dev)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_len_reg <= '0;
            min_reg     <= LEN_MAX;
            max_reg     <= '0;
            sum_reg     <= '0;
            sq_reg      <= '0;
            words_reg   <= '0;
            spaces_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cur_len_reg <= cur_len_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            sum_reg     <= sum_next;
            sq_reg      <= sq_next;
            words_reg   <= words_next;
            spaces_reg  <= spaces_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (term_accept) begin
            min_hold_reg <= (words_f != '0) ? 8'(min_f) : 8'd0;
            max_hold_reg <= 8'(max_f);
            sum_hold_reg <= 16'(sum_f);
            cnt_hold_reg <= 16'(spaces_inc);
        end
        if (load) begin
            m_min_reg  <= min_hold_reg;
            m_max_reg  <= max_hold_reg;
            m_sum_reg  <= sum_hold_reg;
            m_cnt_reg  <= cnt_hold_reg;
            m_mean_reg <= eng_mean;
            m_dev_reg  <= eng_dev;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_min_len      = m_min_reg;
    assign m_max_len      = m_max_reg;
    assign m_letter_total = m_sum_reg;
    assign m_word_count   = m_cnt_reg;
    assign m_mean_q8      = m_mean_reg;
    assign m_stddev_q8    = m_dev_reg;

endmodule

`default_nettype wire

// ===== sv/wls_checker.sv =====
`default_nettype none
`include "word_length_statistics_core_defines.svh"

module wls_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire [7:0]  s_ch,
    input wire        m_valid,
    input wire        m_ready,
    input wire [7:0]  m_min_len,
    input wire [7:0]  m_max_len,
    input wire [15:0] m_letter_total,
    input wire [15:0] m_word_count,
    input wire [23:0] m_mean_q8,
    input wire [15:0] m_stddev_q8
);

    // A stalled result item keeps its fields.
    `WLS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready,
        m_valid && $stable({m_min_len, m_max_len, m_letter_total, m_word_count,
                            m_mean_q8, m_stddev_q8}),
        "result item changed while stalled")

    // The terminator starts the statistics unit, which blocks further bytes.
    `WLS_ASSERT_NEXT(a_term_busy, aclk, aresetn,
        s_valid && s_ready && (s_ch == wls_pkg::CH_NUL), !s_ready,
        "byte accepted right after a terminator")

    // A new result appears only at the end of a busy computation.
    `WLS_ASSERT_SAME(a_result_after_busy, aclk, aresetn, $rose(m_valid), $past(!s_ready),
        "result appeared without a computation")

    // Leaving reset, no result is pending.
    `WLS_ASSERT_NEXT(a_reset_clear, aclk, 1'b1, !aresetn, !m_valid, "result pending after reset")

endmodule

bind word_length_statistics_core wls_checker u_wls_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_ch           (s_ch),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_min_len      (m_min_len),
    .m_max_len      (m_max_len),
    .m_letter_total (m_letter_total),
    .m_word_count   (m_word_count),
    .m_mean_q8      (m_mean_q8),
    .m_stddev_q8    (m_stddev_q8)
);

`default_nettype wire
